>>> hdl/falru_pkg.sv
package falru_pkg;

   localparam int ADDR_W = 32;
   localparam int CAP_W = 5;
   localparam int TOTAL_W = 32;
   localparam int DEFAULT_ENTRIES = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_SHIFT_READ,
      ST_SHIFT_WRITE,
      ST_RESPOND
   } state_type;

endpackage

>>> hdl/falru_ram.sv
module falru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/fully_assoc_lru_cache_tracker_core.sv
// Fully associative LRU address tracker.
// A request is one address on req_address, taken when start is high and busy
// is low. The address is searched among the cached entries, which sit in a
// small RAM in recency order with the most recent entry at address zero.
// A hit moves the entry to the front; a miss inserts the address at the front
// and, if occupancy has reached the capacity, evicts the least recent entry.
// Each request gives one response, shown for exactly one cycle while
// rsp_valid is high, carrying the hit and eviction flags, the evicted address
// and both running totals. The receiver cannot stall the response.
// The search and the shift both go through the single read port of the RAM:
// the search reads and then compares each entry it visits, and the shift
// reads and then writes each position it moves. busy drops in the cycle
// after the response. The user must write the capacity register through
// csr_write_enable and csr_write_data only while the block is idle; the
// block itself does not enforce this. Zero acts as one and values above
// ENTRIES act as ENTRIES. Reset empties the cache, clears the totals and
// sets the capacity to sixteen.
module fully_assoc_lru_cache_tracker_core #(
   parameter int ENTRIES = falru_pkg::DEFAULT_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [falru_pkg::ADDR_W-1:0]  req_address,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic                                 rsp_evicted,
   output logic signed [falru_pkg::ADDR_W-1:0]  rsp_evicted_address,
   output logic [falru_pkg::TOTAL_W-1:0]        rsp_hit_count,
   output logic [falru_pkg::TOTAL_W-1:0]        rsp_miss_count,
   input  logic                                 csr_write_enable,
   input  logic [falru_pkg::CAP_W-1:0]          csr_write_data
);

   import falru_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TOTAL_W-1:0] hit_total_ff, hit_total_in;
   logic [TOTAL_W-1:0] miss_total_ff, miss_total_in;
   logic hit_ff, hit_in;
   logic evicted_ff, evicted_in;
   logic [ADDR_W-1:0] ev_addr_ff, ev_addr_in;

   logic accept;
   logic match;
   logic last;
   logic full;
   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] occ_wide;
   logic [CMP_W-1:0] cap_wide;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ADDR_W-1:0] ram_rdata;

   falru_ram #(
      .WIDTH(ADDR_W),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      accept = start && (state_ff == ST_IDLE);
      match = (ram_rdata == addr_ff);
      last = ((CNT_W'(idx_ff) + 1'b1) == occ_ff);
      cap_wide = CMP_W'(cap_ff);
      occ_wide = CMP_W'(occ_ff);
      if (cap_wide == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_wide > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_wide;
      end
      full = (occ_wide >= cap_eff);
   end

   // Datapath registers.
   always_comb begin
      idx_in = idx_ff;
      occ_in = occ_ff;
      cap_in = cap_ff;
      addr_in = addr_ff;
      hit_total_in = hit_total_ff;
      miss_total_in = miss_total_ff;
      hit_in = hit_ff;
      evicted_in = evicted_ff;
      ev_addr_in = ev_addr_ff;
      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in = req_address;
               hit_in = 1'b0;
               evicted_in = 1'b0;
               ev_addr_in = '0;
               idx_in = '0;
               if (occ_ff == '0) begin
                  miss_total_in = miss_total_ff + 1'b1;
                  occ_in = CNT_W'(1);
               end
            end
         end
         ST_COMPARE: begin
            if (match) begin
               hit_in = 1'b1;
               hit_total_in = hit_total_ff + 1'b1;
            end else if (last) begin
               miss_total_in = miss_total_ff + 1'b1;
               if (full) begin
                  evicted_in = 1'b1;
                  ev_addr_in = ram_rdata;
               end else begin
                  idx_in = IDX_W'(occ_ff);
                  occ_in = occ_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SHIFT_WRITE: begin
            if (idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (occ_ff == '0) ? ST_SHIFT_WRITE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (match || last) begin
               state_in = (idx_in == '0) ? ST_SHIFT_WRITE : ST_SHIFT_READ;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SHIFT_READ: begin
            state_in = ST_SHIFT_WRITE;
         end
         ST_SHIFT_WRITE: begin
            if (idx_ff == '0) begin
               state_in = ST_RESPOND;
            end else if (idx_in == '0) begin
               state_in = ST_SHIFT_WRITE;
            end else begin
               state_in = ST_SHIFT_READ;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and RAM control.
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff;
      busy = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         ST_SHIFT_READ: begin
            ram_raddr = idx_ff - 1'b1;
         end
         ST_SHIFT_WRITE: begin
            ram_we = 1'b1;
            ram_wdata = (idx_ff == '0) ? addr_ff : ram_rdata;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff <= '0;
         cap_ff <= CAP_RESET;
         hit_total_ff <= '0;
         miss_total_ff <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         cap_ff <= cap_in;
         hit_total_ff <= hit_total_in;
         miss_total_ff <= miss_total_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      addr_ff <= addr_in;
      hit_ff <= hit_in;
      evicted_ff <= evicted_in;
      ev_addr_ff <= ev_addr_in;
   end

   assign rsp_hit = hit_ff;
   assign rsp_evicted = evicted_ff;
   assign rsp_evicted_address = ev_addr_ff;
   assign rsp_hit_count = hit_total_ff;
   assign rsp_miss_count = miss_total_ff;

endmodule

>>> hdl/falru_checker.sv
module falru_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic                                rsp_hit,
   input logic                                rsp_evicted,
   input logic signed [falru_pkg::ADDR_W-1:0] rsp_evicted_address
);

   import falru_pkg::*;

   // An accepted request keeps the block busy until its response is out.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted but busy did not rise");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response shown while idle");

   // Exactly one response per request, then the block is free again.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> (!busy && !rsp_valid))
      else $error("block stayed busy after its response");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("a hit cannot evict");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_address == '0))
      else $error("evicted address not zero without eviction");

endmodule

bind fully_assoc_lru_cache_tracker_core falru_checker u_falru_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_hit(rsp_hit),
   .rsp_evicted(rsp_evicted),
   .rsp_evicted_address(rsp_evicted_address)
);
